>>> sv/npcs_pkg.sv
// Shared constants and types for the nearest palette colour search block.
package npcs_pkg;

    localparam int PALETTE_ENTRIES_DEF = 256;
    localparam int COLOR_W = 16;
    localparam int CHAN_W = 8;
    localparam int IDX_OUT_W = 8;
    localparam int SQ_W = 2 * CHAN_W;
    localparam int DIST_W = SQ_W + 2;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_REPORT
    } state_t;

endpackage

>>> sv/nearest_palette_color_search.sv
// Top level: palette store and nearest-colour search over it with one distance unit.
// A write item leaves busy low, so the next item may follow at once.
// A query item walks every palette entry through the distance unit, one entry a cycle;
// done strobes once the last entry's distance has been compared, and the next item is
// taken after done, when the sequencer is back in idle; there is no receiver stall.
// Reset clears the sequencer and the best-match registers; the palette holds no defined value until written.
module nearest_palette_color_search
    import npcs_pkg::*;
#(
    parameter int PALETTE_ENTRIES = PALETTE_ENTRIES_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic                 operation,
    input  logic [7:0]           entry_index,
    input  logic [COLOR_W-1:0]   entry_color,
    input  logic [CHAN_W-1:0]    query_red,
    input  logic [CHAN_W-1:0]    query_green,
    input  logic [CHAN_W-1:0]    query_blue,
    output logic                 done,
    output logic [IDX_OUT_W-1:0] best_index
);

    localparam int IDX_W = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
    localparam int WIDE_W = ((IDX_W > 8) ? IDX_W : 8) + 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PALETTE_ENTRIES - 1);
    localparam logic [DIST_W-1:0] DIST_MAX = '1;

    state_t state_reg, state_next;

    logic              accept;
    logic              issue;
    logic [WIDE_W-1:0] wide_idx;
    logic              wr_en;

    logic [IDX_W-1:0]  issue_cnt_reg, issue_cnt_next;
    logic [CHAN_W-1:0] q_red_reg, q_green_reg, q_blue_reg;

    logic [COLOR_W-1:0] rdata;
    logic               rd_v_reg;
    logic [IDX_W-1:0]   rd_idx_reg;

    logic [CHAN_W-1:0] diff_r, diff_g, diff_b;
    logic              sq_v_reg;
    logic [IDX_W-1:0]  sq_idx_reg;
    logic [SQ_W-1:0]   sq_r_reg, sq_g_reg, sq_b_reg;

    logic [DIST_W-1:0] cand_dist;
    logic [DIST_W-1:0] best_dist_reg;
    logic [IDX_W-1:0]  best_idx_reg;
    logic              last_done;

    assign accept   = start && !busy;
    assign wide_idx = WIDE_W'(entry_index);
    assign wr_en    = accept && (operation == OP_WRITE)
                      && (wide_idx < WIDE_W'(PALETTE_ENTRIES));

    npcs_ram #(
        .WIDTH (COLOR_W),
        .DEPTH (PALETTE_ENTRIES),
        .AW    (IDX_W)
    ) u_palette (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wide_idx[IDX_W-1:0]),
        .wdata (entry_color),
        .raddr (issue_cnt_reg),
        .rdata (rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            issue_cnt_reg <= '0;
            rd_v_reg      <= 1'b0;
            sq_v_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            issue_cnt_reg <= issue_cnt_next;
            rd_v_reg      <= issue;
            sq_v_reg      <= rd_v_reg;
        end
    end

    assign last_done = sq_v_reg && (sq_idx_reg == LAST_IDX);

    always_comb
    begin
        state_next     = state_reg;
        issue_cnt_next = issue_cnt_reg;
        busy           = 1'b1;
        done           = 1'b0;
        issue          = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                busy = 1'b0;
                if (accept && (operation == OP_QUERY))
                begin
                    state_next     = ST_SCAN;
                    issue_cnt_next = '0;
                end
            end
            ST_SCAN:
            begin
                issue = 1'b1;
                if (issue_cnt_reg == LAST_IDX)
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    issue_cnt_next = issue_cnt_reg + 1'b1;
                end
            end
            ST_DRAIN:
            begin
                if (last_done)
                begin
                    state_next = ST_REPORT;
                end
            end
            ST_REPORT:
            begin
                done       = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold the query colour for the whole scan.
    always_ff @(posedge clk)
    begin
        if (accept && (operation == OP_QUERY))
        begin
            q_red_reg   <= query_red;
            q_green_reg <= query_green;
            q_blue_reg  <= query_blue;
        end
        rd_idx_reg <= issue_cnt_reg;
    end

    always_comb
    begin
        logic [CHAN_W-1:0] pr, pg, pb;
        pr = CHAN_W'(rdata[15:11]);
        pg = CHAN_W'(rdata[10:5]);
        pb = CHAN_W'(rdata[4:0]);
        diff_r = (q_red_reg > pr)   ? (q_red_reg - pr)   : (pr - q_red_reg);
        diff_g = (q_green_reg > pg) ? (q_green_reg - pg) : (pg - q_green_reg);
        diff_b = (q_blue_reg > pb)  ? (q_blue_reg - pb)  : (pb - q_blue_reg);
    end

    always_ff @(posedge clk)
    begin
        sq_idx_reg <= rd_idx_reg;
        sq_r_reg   <= SQ_W'(diff_r) * SQ_W'(diff_r);
        sq_g_reg   <= SQ_W'(diff_g) * SQ_W'(diff_g);
        sq_b_reg   <= SQ_W'(diff_b) * SQ_W'(diff_b);
    end

    assign cand_dist = DIST_W'(sq_r_reg) + DIST_W'(sq_g_reg) + DIST_W'(sq_b_reg);

    // Keep the first entry with the least distance; strict compare drops later ties.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_dist_reg <= DIST_MAX;
            best_idx_reg  <= '0;
        end
        else if (accept && (operation == OP_QUERY))
        begin
            best_dist_reg <= DIST_MAX;
            best_idx_reg  <= '0;
        end
        else if (sq_v_reg && (cand_dist < best_dist_reg))
        begin
            best_dist_reg <= cand_dist;
            best_idx_reg  <= sq_idx_reg;
        end
    end

    assign best_index = IDX_OUT_W'(best_idx_reg);

endmodule

>>> sv/npcs_ram.sv
// Generic single-write, single-read RAM with registered read data.
module npcs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256,
    parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule
